// ===== src/irpd_pkg.sv =====
// Shared types, constants and codes of the infrared pulse-distance sender.
package irpd_pkg;

	// Default widths of the timer intervals and of the code word.
	localparam int TIME_WIDTH_DEF = 20;
	localparam int CODE_WIDTH_DEF = 32;

	// Fixed widths of the channel fields.
	localparam int LEN_OUT_W  = 20;
	localparam int CODE_IN_W  = 32;
	localparam int REPEAT_W   = 8;
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = 3;

	// Settling wait answered to a start item, in timer ticks.
	localparam logic [63:0] START_WAIT = 64'd100000;

	// Item opcodes.
	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} irpd_op_e;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_HEADER_PULSE  = 3'd0,
		REG_HEADER_SPACE  = 3'd1,
		REG_ONE_PULSE     = 3'd2,
		REG_ZERO_PULSE    = 3'd3,
		REG_ONE_SPACE     = 3'd4,
		REG_ZERO_SPACE    = 3'd5,
		REG_TRAILER_PULSE = 3'd6,
		REG_GAP_SPACE     = 3'd7
	} irpd_reg_e;

	// Frame sequencer phases.
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_CODE   = 2'd2,
		PH_TRAIL  = 2'd3
	} irpd_phase_e;

	// One input item.
	typedef struct packed {
		logic                 opcode;
		logic [CODE_IN_W-1:0] code_word;
		logic [CODE_IN_W-1:0] start_mask;
		logic [REPEAT_W-1:0]  repeat_count;
	} irpd_item_t;

	// One result item.
	typedef struct packed {
		logic                 carrier_on;
		logic [LEN_OUT_W-1:0] interval_len;
		logic                 finished;
		logic                 busy_res;
	} irpd_res_t;

endpackage

// ===== src/irpd_if.sv =====
// Channel interfaces of the sender: input items, result items and register writes.
interface irpd_in_if import irpd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [CODE_IN_W-1:0] code_word;
	logic [CODE_IN_W-1:0] start_mask;
	logic [REPEAT_W-1:0]  repeat_count;

	modport source (output valid, opcode, code_word, start_mask, repeat_count, input ready);
	modport sink (input valid, opcode, code_word, start_mask, repeat_count, output ready);
endinterface

interface irpd_out_if import irpd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 carrier_on;
	logic [LEN_OUT_W-1:0] interval_len;
	logic                 finished;
	logic                 busy_res;

	modport source (output valid, carrier_on, interval_len, finished, busy_res, input ready);
	modport sink (input valid, carrier_on, interval_len, finished, busy_res, output ready);
endinterface

interface irpd_cfg_if import irpd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [LEN_OUT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/irpd_cfg_regs.sv =====
// Interval length registers written through the configuration channel.
module irpd_cfg_regs import irpd_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          wr_en,
	input  logic [REG_IDX_W-1:0]                          wr_index,
	input  logic [LEN_OUT_W-1:0]                          wr_data,
	output logic [NUM_REGS-1:0][((TIME_WIDTH < LEN_OUT_W) ? TIME_WIDTH : LEN_OUT_W)-1:0] lens
);

	localparam int LEN_W = (TIME_WIDTH < LEN_OUT_W) ? TIME_WIDTH : LEN_OUT_W;

	logic [NUM_REGS-1:0][LEN_W-1:0] len_q;

	// Each write lands in the register that its index selects.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (wr_en) begin
			len_q[wr_index] <= LEN_W'(wr_data);
		end
	end

	assign lens = len_q;

endmodule

// ===== src/irpd_seq.sv =====
// Frame sequencer: state registers and the single-step next-interval logic.
module irpd_seq import irpd_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          step_en,
	input  irpd_item_t                                    item,
	input  logic [NUM_REGS-1:0][((TIME_WIDTH < LEN_OUT_W) ? TIME_WIDTH : LEN_OUT_W)-1:0] lens,
	output irpd_res_t                                     res
);

	localparam int LEN_W = (TIME_WIDTH < LEN_OUT_W) ? TIME_WIDTH : LEN_OUT_W;
	localparam logic [63:0] TIME_MAX  = (64'd1 << TIME_WIDTH) - 64'd1;
	localparam logic [63:0] START_LEN = (START_WAIT > TIME_MAX) ? TIME_MAX : START_WAIT;

	irpd_phase_e           phase_q, phase_d;
	logic                  next_carrier_q, next_carrier_d;
	logic [CODE_WIDTH-1:0] bit_mask_q, bit_mask_d;
	logic [CODE_WIDTH-1:0] mask_saved_q, mask_saved_d;
	logic [CODE_WIDTH-1:0] code_held_q, code_held_d;
	logic [REPEAT_W-1:0]   repeats_left_q, repeats_left_d;
	logic [LEN_W-1:0]      len_sel;
	logic                  is_one;
	logic [CODE_WIDTH-1:0] mask_shr;

	// State registers advance only when an item is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			next_carrier_q <= 1'b0;
			bit_mask_q     <= '0;
			mask_saved_q   <= '0;
			code_held_q    <= '0;
			repeats_left_q <= '0;
		end else if (step_en) begin
			phase_q        <= phase_d;
			next_carrier_q <= next_carrier_d;
			bit_mask_q     <= bit_mask_d;
			mask_saved_q   <= mask_saved_d;
			code_held_q    <= code_held_d;
			repeats_left_q <= repeats_left_d;
		end
	end

	assign is_one   = |(bit_mask_q & code_held_q);
	assign mask_shr = bit_mask_q >> 1;

	// Next state and the answer for the item at hand.
	always_comb begin
		phase_d        = phase_q;
		next_carrier_d = next_carrier_q;
		bit_mask_d     = bit_mask_q;
		mask_saved_d   = mask_saved_q;
		code_held_d    = code_held_q;
		repeats_left_d = repeats_left_q;
		len_sel        = '0;
		res            = '0;

		if (item.opcode == OP_START) begin
			// A start reloads everything and aborts any running frame.
			code_held_d    = CODE_WIDTH'(item.code_word);
			bit_mask_d     = CODE_WIDTH'(item.start_mask);
			mask_saved_d   = CODE_WIDTH'(item.start_mask);
			repeats_left_d = (item.repeat_count == '0) ? REPEAT_W'(1) : item.repeat_count;
			phase_d        = PH_HEADER;
			next_carrier_d = 1'b1;
			res.interval_len = LEN_OUT_W'(START_LEN);
			res.busy_res     = 1'b1;
		end else if (phase_q != PH_IDLE) begin
			res.carrier_on = next_carrier_q;
			res.busy_res   = 1'b1;
			next_carrier_d = !next_carrier_q;
			unique case (phase_q)
				PH_HEADER: begin
					if (next_carrier_q) begin
						len_sel = lens[REG_HEADER_PULSE];
					end else begin
						len_sel = lens[REG_HEADER_SPACE];
						phase_d = PH_CODE;
					end
				end
				PH_CODE: begin
					if (next_carrier_q) begin
						len_sel = is_one ? lens[REG_ONE_PULSE] : lens[REG_ZERO_PULSE];
					end else begin
						len_sel    = is_one ? lens[REG_ONE_SPACE] : lens[REG_ZERO_SPACE];
						bit_mask_d = mask_shr;
						if (mask_shr == '0) begin
							phase_d = PH_TRAIL;
						end
					end
				end
				PH_TRAIL: begin
					if (next_carrier_q) begin
						len_sel = lens[REG_TRAILER_PULSE];
						if (repeats_left_q != '0) begin
							repeats_left_d = repeats_left_q - REPEAT_W'(1);
						end
					end else if (repeats_left_q != '0) begin
						len_sel    = lens[REG_GAP_SPACE];
						bit_mask_d = mask_saved_q;
						phase_d    = PH_CODE;
					end else begin
						// Frame complete: stop timing and go idle.
						phase_d        = PH_IDLE;
						next_carrier_d = 1'b0;
						res.carrier_on = 1'b0;
						res.busy_res   = 1'b0;
						res.finished   = 1'b1;
					end
				end
				PH_IDLE: begin
				end
			endcase
			res.interval_len = LEN_OUT_W'(len_sel);
		end
	end

	// The idle phase never holds a pending carrier-on interval.
	a_idle_no_carrier: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !next_carrier_q)
		else $error("idle phase with carrier pending");

	// Header and code phases always have at least one pass left.
	a_repeats_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER || phase_q == PH_CODE) |-> repeats_left_q != '0)
		else $error("frame in progress with no pass left");

	// A start item always opens the header with a pulse.
	a_start_header: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.opcode == OP_START |=> phase_q == PH_HEADER && next_carrier_q)
		else $error("start did not enter the header");

	// A tick while idle leaves the sequencer idle.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.opcode == OP_TICK && phase_q == PH_IDLE |=> phase_q == PH_IDLE)
		else $error("tick while idle changed the phase");

	// Finishing always comes with busy low and a zero interval.
	a_finish_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.finished |-> !res.busy_res && res.interval_len == '0 && phase_d == PH_IDLE)
		else $error("finish answer inconsistent");

endmodule

// ===== src/ir_pulse_distance_sender_core.sv =====
// Top level of the infrared pulse-distance frame sender.
//
// Channel  Direction  Handshake     Payload
// in_ch    sink       valid/ready   opcode, code_word, start_mask, repeat_count
// out_ch   source     valid/ready   carrier_on, interval_len, finished, busy_res
// cfg      sink       valid/ready   index, data (ready is always high)
//
// Every item gives one result: it passes through the input register, then the result
// register. One item is accepted per cycle while the result is not stalled.
// The sequencer state updates when an item moves from the input register to the
// result register, which computes the whole frame step combinationally.
// A stalled result holds in the result register while one more item waits in the
// input register; only then does in_ch.ready drop.
// Reset is asynchronous and clears the pipeline, the sequencer and the registers.
module ir_pulse_distance_sender_core import irpd_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	irpd_in_if.sink    in_ch,
	irpd_out_if.source out_ch,
	irpd_cfg_if.sink   cfg
);

	localparam int LEN_W = (TIME_WIDTH < LEN_OUT_W) ? TIME_WIDTH : LEN_OUT_W;

	irpd_item_t                     item_s1;
	logic                           valid_s1;
	irpd_res_t                      res_s2;
	logic                           valid_s2;
	irpd_res_t                      step_res;
	logic                           advance;
	logic                           in_accept;
	logic [NUM_REGS-1:0][LEN_W-1:0] lens;

	assign advance   = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_accept = in_ch.valid && in_ch.ready;

	assign in_ch.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	// Register file for the interval lengths.
	irpd_cfg_regs #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.lens     (lens)
	);

	// Frame sequencer working on the item in the input register.
	irpd_seq #(
		.TIME_WIDTH(TIME_WIDTH),
		.CODE_WIDTH(CODE_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.lens    (lens),
		.res     (step_res)
	);

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.opcode       <= in_ch.opcode;
			item_s1.code_word    <= in_ch.code_word;
			item_s1.start_mask   <= in_ch.start_mask;
			item_s1.repeat_count <= in_ch.repeat_count;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.carrier_on   = res_s2.carrier_on;
	assign out_ch.interval_len = res_s2.interval_len;
	assign out_ch.finished     = res_s2.finished;
	assign out_ch.busy_res     = res_s2.busy_res;

	// An item waits in the input register only while the result is stalled.
	a_s1_waits_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> valid_s2 && !out_ch.ready)
		else $error("input register held without an output stall");

	// A stalled result keeps the input register from advancing into it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |=> valid_s2 && $stable(res_s2))
		else $error("stalled result was overwritten");

	// A consumed item always produces a result in the next cycle.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("consumed item left no result");

endmodule
